// File: rtl/lsf_pkg.sv
// Package for the last line substring finder.
// Holds payload structs, register indexes and fixed constants; no dependencies.
package lsf_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned PAT_LEN_W   = 5;
    localparam int unsigned PAT_BITS    = 128;

    localparam logic [7:0] LINE_END = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_text;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] line_index;
    } out_item_t;

endpackage

// File: rtl/lsf_match.sv
// Window compare: does the configured pattern end at the current byte.
// Uses lsf_pkg; instantiated by last_line_substring_finder.
module lsf_match #(
    parameter int PATTERN_MAX = 16
) (
    input  logic [7:0]                                              cur_byte,
    input  logic [((PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1)-1:0][7:0] window,
    input  logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] line_count,
    input  logic [lsf_pkg::PAT_BITS-1:0]                             pattern,
    input  logic [lsf_pkg::PAT_LEN_W-1:0]                            pattern_length,
    output logic                                                     hit
);
    import lsf_pkg::*;

    localparam int CNT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] hit_by_len;
    logic [CNT_W-1:0]       len_sel;

    // candidate pattern length l+1 ends at cur_byte
    always_comb begin
        for (int l = 0; l < PATTERN_MAX; l++) begin
            hit_by_len[l] = (pattern[8*l +: 8] == cur_byte) && (line_count >= CNT_W'(l));
            for (int j = 0; j < l; j++) begin
                if (pattern[8*j +: 8] != window[l-1-j]) begin
                    hit_by_len[l] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (pattern_length == '0) begin
            len_sel = '0;
        end else if (pattern_length > PAT_LEN_W'(PATTERN_MAX)) begin
            len_sel = CNT_W'(PATTERN_MAX - 1);
        end else begin
            len_sel = CNT_W'(pattern_length - PAT_LEN_W'(1));
        end
    end

    assign hit = hit_by_len[len_sel];

endmodule

// File: rtl/last_line_substring_finder.sv
// Top level of the last line substring finder.
// Uses lsf_pkg and lsf_match.
//
// Usage:
//   Text enters one byte per transaction on the s_ channel (s_valid/s_ready,
//   payload s_data). Byte 10 ends a line; lines are numbered from zero.
//   The transaction with last_of_text set yields one result on the m_ channel
//   (m_valid/m_ready, payload m_data): found, and the index of the last
//   newline-terminated line that holds the pattern. Other bytes yield nothing.
//   The cfg channel writes pattern_low (0), pattern_high (1) and
//   pattern_length (2); the user must write them only while the block is
//   idle, which the block itself does not enforce; cfg_ready is always high.
//   Throughput is one byte per cycle while s_ready is high: the window
//   compare and line bookkeeping sit between the state and output registers.
//   An output register plus a skid register decouple the sides: bytes keep
//   flowing while a result waits; s_ready drops only when a second result is
//   held in the skid register behind a stalled one.
//   Synchronous reset (aresetn low) clears the text state and both result
//   slots and loads the pattern registers with zero and length one.
//   After each last byte the text state returns to its reset values.
module last_line_substring_finder #(
    parameter int PATTERN_MAX     = 16,
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lsf_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lsf_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lsf_pkg::*;

    localparam int WIN   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int CNT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;

    logic [CFG_DATA_W-1:0]      pat_low_reg, pat_high_reg;
    logic [PAT_LEN_W-1:0]       pat_len_reg;

    logic [WIN-1:0][7:0]        window_reg, window_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       matched_reg, matched_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;
    logic [LINE_COUNT_BITS-1:0] best_reg, best_next;
    logic                       any_reg, any_next;

    logic                       m_valid_reg, m_valid_next;
    out_item_t                  m_data_reg, m_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    out_item_t                  skid_data_reg, skid_data_next;

    logic                       accept_in;
    logic                       hit;
    out_item_t                  result;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept_in = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= PAT_LEN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                REG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    lsf_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .cur_byte       (s_data.text_byte),
        .window         (window_reg),
        .line_count     (count_reg),
        .pattern        ({pat_high_reg, pat_low_reg}),
        .pattern_length (pat_len_reg),
        .hit            (hit)
    );

    always_comb begin
        window_next  = window_reg;
        count_next   = count_reg;
        matched_next = matched_reg;
        line_next    = line_reg;
        best_next    = best_reg;
        any_next     = any_reg;
        if (s_data.text_byte == LINE_END) begin
            if (matched_reg) begin
                any_next  = 1'b1;
                best_next = line_reg;
            end
            if (line_reg != LINE_MAX) begin
                line_next = line_reg + LINE_COUNT_BITS'(1);
            end
            window_next  = '0;
            count_next   = '0;
            matched_next = 1'b0;
        end else begin
            if (hit) begin
                matched_next = 1'b1;
            end
            for (int i = WIN - 1; i > 0; i--) begin
                window_next[i] = window_reg[i-1];
            end
            window_next[0] = s_data.text_byte;
            if (count_reg != CNT_W'(WIN)) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        result.found      = any_next;
        result.line_index = any_next ? 16'(best_next) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            count_reg   <= '0;
            matched_reg <= 1'b0;
            line_reg    <= '0;
            best_reg    <= '0;
            any_reg     <= 1'b0;
        end else if (accept_in) begin
            if (s_data.last_of_text) begin
                window_reg  <= '0;
                count_reg   <= '0;
                matched_reg <= 1'b0;
                line_reg    <= '0;
                best_reg    <= '0;
                any_reg     <= 1'b0;
            end else begin
                window_reg  <= window_next;
                count_reg   <= count_next;
                matched_reg <= matched_next;
                line_reg    <= line_next;
                best_reg    <= best_next;
                any_reg     <= any_next;
            end
        end
    end

    // output register with one skid slot behind it
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = accept_in && s_data.last_of_text;
                m_data_next  = result;
            end
        end else if (accept_in && s_data.last_of_text) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/lsf_checker.sv
// Port-level checker for last_line_substring_finder, with its bind statement.
// Uses lsf_pkg; sees the top level's ports only.
module lsf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input lsf_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input lsf_pkg::out_item_t m_data
);
    import lsf_pkg::*;

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.line_index == 16'd0)
        else $error("line index set without a match");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_of_text))
        else $error("result without a last byte transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled while the output was free");

endmodule

bind last_line_substring_finder lsf_checker u_lsf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
